// ----- hw/rtl/swps_pkg.sv -----
package swps_pkg;

	localparam int MINUTE_WIDTH_DEF = 16;
	localparam int POS_W            = 5;
	localparam int TICK_W           = 13;
	localparam int FALLBACK_W       = 16;
	localparam int SLEEP_LEFT_W     = 16;
	localparam int OUT_DATA_W       = 24;
	localparam int ADDR_W           = 3;

	localparam logic [POS_W-1:0] CMD_LEN        = 5'd16;
	localparam logic [POS_W-1:0] CMD_DIGITS_POS = 5'd10;
	localparam logic [POS_W-1:0] CMD_UNIT_POS   = 5'd12;
	localparam logic [POS_W-1:0] CMD_MODE_POS   = 5'd15;
	localparam logic [POS_W-1:0] HALT_LEN       = 5'd21;

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [7:0] CHAR_M    = 8'h6d;

	localparam logic [TICK_W-1:0]     TPM_RESET      = 13'd6000;
	localparam logic [FALLBACK_W-1:0] FALLBACK_RESET = 16'd1440;

	localparam logic [ADDR_W-1:0] REG_TPM_ADDR      = 3'd0;
	localparam logic [ADDR_W-1:0] REG_FALLBACK_ADDR = 3'd4;

	typedef enum logic [1:0] {
		ACT_BYTE   = 2'd0,
		ACT_TICK   = 2'd1,
		ACT_BUTTON = 2'd2,
		ACT_NONE   = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		LED_GRN    = 2'd0,
		LED_BLINK  = 2'd1,
		LED_RED    = 2'd2,
		LED_UNUSED = 2'd3
	} led_t;

	typedef enum logic {
		PWR_OFF = 1'b0,
		PWR_ON  = 1'b1
	} pwr_state_t;

	typedef struct packed {
		logic cmd_done;
		logic halt;
		logic mode;
	} match_evt_t;

	// sleep command text, digit positions hold zero
	function automatic logic [7:0] cmd_char(input logic [POS_W-1:0] p);
		logic [7:0] ch;
		unique case (p)
			5'd0:    ch = 8'h53;
			5'd1:    ch = 8'h4c;
			5'd2:    ch = 8'h45;
			5'd3:    ch = 8'h45;
			5'd4:    ch = 8'h50;
			5'd5:    ch = 8'h54;
			5'd6:    ch = 8'h49;
			5'd7:    ch = 8'h4d;
			5'd8:    ch = 8'h45;
			5'd9:    ch = 8'h20;
			5'd11:   ch = 8'h6d;
			5'd12:   ch = 8'h69;
			5'd13:   ch = 8'h6e;
			5'd14:   ch = 8'h3a;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// "reboot: System halted"
	function automatic logic [7:0] halt_char(input logic [POS_W-1:0] p);
		logic [7:0] ch;
		unique case (p)
			5'd0:    ch = 8'h72;
			5'd1:    ch = 8'h65;
			5'd2:    ch = 8'h62;
			5'd3:    ch = 8'h6f;
			5'd4:    ch = 8'h6f;
			5'd5:    ch = 8'h74;
			5'd6:    ch = 8'h3a;
			5'd7:    ch = 8'h20;
			5'd8:    ch = 8'h53;
			5'd9:    ch = 8'h79;
			5'd10:   ch = 8'h73;
			5'd11:   ch = 8'h74;
			5'd12:   ch = 8'h65;
			5'd13:   ch = 8'h6d;
			5'd14:   ch = 8'h20;
			5'd15:   ch = 8'h68;
			5'd16:   ch = 8'h61;
			5'd17:   ch = 8'h6c;
			5'd18:   ch = 8'h74;
			5'd19:   ch = 8'h65;
			5'd20:   ch = 8'h64;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

// ----- hw/rtl/sleep_wake_power_sequencer.sv -----
// channel   direction  tdata (low bit up)                                   tuser
// s_axis    in         rx_byte[7:0]                                         action[1:0]
// m_axis    out        relay_on, led_mode[1:0], shutdown_request,           -
//                      sleep_left[15:0], 4 zero bits
// apb       in/out     ticks_per_minute at 0x0, fallback_minutes at 0x4     -
//
// one event per cycle while results are taken: input register, one step of matcher and power logic, result register
// the event passes two registers on its way to a valid result: the input register, then the result register
// reset brings the host-on state with steady red led and an empty sleep time; no clearing pass
// a stalled result holds the pipeline; the input register still takes one more event
module sleep_wake_power_sequencer
	import swps_pkg::*;
#(
	parameter int MINUTE_WIDTH = MINUTE_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,   // rx_byte
	input  logic [1:0]            s_axis_tuser,   // action
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,   // relay_on, led_mode, shutdown_request,
	                                              // sleep_left, zero fill
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	logic                    valid_s1;
	act_t                    act_s1;
	logic [7:0]              byte_s1;
	logic                    out_valid_q;
	logic [OUT_DATA_W-1:0]   out_data_q;
	logic                    advance, step, byte_step;
	logic [TICK_W-1:0]       tpm_q;
	logic [FALLBACK_W-1:0]   fallback_q;
	logic                    cfg_wr;
	match_evt_t              evt;
	logic [MINUTE_WIDTH-1:0] minutes;
	logic                    relay_on, shutdown_request;
	led_t                    led_mode;
	logic [SLEEP_LEFT_W-1:0] sleep_left;

	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign step          = valid_s1 && advance;
	assign byte_step     = step && (act_s1 == ACT_BYTE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			act_s1  <= act_t'(s_axis_tuser);
			byte_s1 <= s_axis_tdata;
		end
	end

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpm_q      <= TPM_RESET;
			fallback_q <= FALLBACK_RESET;
		end else if (cfg_wr) begin
			if (paddr == REG_TPM_ADDR) begin
				tpm_q <= pwdata[TICK_W-1:0];
			end
			if (paddr == REG_FALLBACK_ADDR) begin
				fallback_q <= pwdata[FALLBACK_W-1:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == REG_TPM_ADDR) begin
			prdata = 32'(tpm_q);
		end else if (paddr == REG_FALLBACK_ADDR) begin
			prdata = 32'(fallback_q);
		end
	end

	swps_match #(
		.MINUTE_WIDTH(MINUTE_WIDTH)
	) u_match (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (byte_step),
		.rx_byte (byte_s1),
		.evt     (evt),
		.minutes (minutes)
	);

	swps_power #(
		.MINUTE_WIDTH(MINUTE_WIDTH)
	) u_power (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (step),
		.action           (act_s1),
		.evt              (evt),
		.minutes          (minutes),
		.ticks_per_minute (tpm_q),
		.fallback_minutes (fallback_q),
		.relay_on         (relay_on),
		.led_mode         (led_mode),
		.shutdown_request (shutdown_request),
		.sleep_left       (sleep_left)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_data_q <= {4'b0000, sleep_left, shutdown_request, led_mode, relay_on};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`ifndef SYNTH
	a_request_only_when_on: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[0])
		else $error("shutdown request with relay open");

	a_no_take_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |-> !s_axis_tready)
		else $error("input taken while stage one is stalled");

	a_stage_one_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("stalled event lost from stage one");
`endif

endmodule

// ----- hw/rtl/swps_match.sv -----
module swps_match
	import swps_pkg::*;
#(
	parameter int MINUTE_WIDTH = MINUTE_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  logic [7:0]              rx_byte,
	output match_evt_t              evt,
	output logic [MINUTE_WIDTH-1:0] minutes
);

	logic [POS_W-1:0]        cmd_pos_q, cmd_pos_d;
	logic [MINUTE_WIDTH-1:0] acc_q, acc_d, acc10;
	logic                    mode_q, mode_d;
	logic [POS_W-1:0]        halt_pos_q, halt_pos_d;

	logic [POS_W-1:0] p, p_n, hp, hp_n;
	logic             is_digit, miss, cmd_done, halt_done;

	assign is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
	// times ten plus the digit, wrapping at the accumulator width
	assign acc10 = (acc_q << 3) + (acc_q << 1) + MINUTE_WIDTH'(rx_byte[3:0]);

	always_comb begin
		p      = (cmd_pos_q >= CMD_LEN) ? '0 : cmd_pos_q;
		p_n    = p;
		acc_d  = acc_q;
		mode_d = mode_q;
		miss   = 1'b0;
		if (p == CMD_DIGITS_POS) begin
			if (is_digit) begin
				acc_d = acc10;
			end else if (rx_byte == CHAR_M) begin
				p_n = CMD_UNIT_POS;
			end else begin
				miss = 1'b1;
			end
		end else if (p == CMD_MODE_POS) begin
			if (is_digit) begin
				mode_d = rx_byte[0];
				p_n    = p + 1'b1;
			end else begin
				miss = 1'b1;
			end
		end else if (rx_byte == cmd_char(p)) begin
			p_n = p + 1'b1;
		end else begin
			miss = 1'b1;
		end
		if (miss) begin
			p_n   = '0;
			acc_d = '0;
		end
		cmd_done  = (p_n == CMD_LEN);
		cmd_pos_d = cmd_done ? '0 : p_n;
	end

	always_comb begin
		hp         = (halt_pos_q >= HALT_LEN) ? '0 : halt_pos_q;
		hp_n       = (rx_byte == halt_char(hp)) ? hp + 1'b1 : '0;
		halt_done  = (hp_n == HALT_LEN);
		halt_pos_d = halt_done ? '0 : hp_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_pos_q  <= '0;
			acc_q      <= '0;
			mode_q     <= 1'b0;
			halt_pos_q <= '0;
		end else if (step) begin
			cmd_pos_q  <= cmd_pos_d;
			acc_q      <= acc_d;
			mode_q     <= mode_d;
			halt_pos_q <= halt_pos_d;
		end
	end

	assign evt.cmd_done = cmd_done;
	assign evt.halt     = halt_done;
	assign evt.mode     = mode_d;
	assign minutes      = acc_d;

endmodule

// ----- hw/rtl/swps_power.sv -----
module swps_power
	import swps_pkg::*;
#(
	parameter int MINUTE_WIDTH = MINUTE_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  act_t                    action,
	input  match_evt_t              evt,
	input  logic [MINUTE_WIDTH-1:0] minutes,
	input  logic [TICK_W-1:0]       ticks_per_minute,
	input  logic [FALLBACK_W-1:0]   fallback_minutes,
	output logic                    relay_on,
	output led_t                    led_mode,
	output logic                    shutdown_request,
	output logic [SLEEP_LEFT_W-1:0] sleep_left
);

	pwr_state_t              state_q, state_d;
	led_t                    led_q, led_d;
	logic [TICK_W-1:0]       tick_q, tick_d, tick_dec;
	logic [MINUTE_WIDTH-1:0] sleep_q, sleep_d, sleep_cmd, fallback_w;
	logic                    smode_q, smode_d, smode_cmd;
	logic                    req, alarm;
	logic [31:0]             fallback_32, sleep_32;

	assign fallback_32 = 32'(fallback_minutes);
	assign fallback_w  = fallback_32[MINUTE_WIDTH-1:0];
	assign tick_dec    = tick_q - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PWR_ON;
		end else if (step) begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_q   <= LED_RED;
			tick_q  <= TPM_RESET;
			sleep_q <= '0;
			smode_q <= 1'b0;
		end else if (step) begin
			led_q   <= led_d;
			tick_q  <= tick_d;
			sleep_q <= sleep_d;
			smode_q <= smode_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		led_d     = led_q;
		tick_d    = tick_q;
		sleep_d   = sleep_q;
		smode_d   = smode_q;
		req       = 1'b0;
		alarm     = 1'b0;
		sleep_cmd = evt.cmd_done ? minutes : sleep_q;
		smode_cmd = evt.cmd_done ? evt.mode : smode_q;
		unique case (action)
			ACT_BYTE: begin
				sleep_d = sleep_cmd;
				smode_d = smode_cmd;
				if (evt.halt && state_q == PWR_ON) begin
					// no sleep time set: fall back and blink
					if (sleep_cmd == '0) begin
						sleep_d = fallback_w;
						smode_d = 1'b1;
					end
					led_d   = smode_d ? LED_BLINK : LED_GRN;
					state_d = PWR_OFF;
				end
			end
			ACT_TICK: begin
				tick_d = tick_dec;
				if (tick_dec == '0) begin
					tick_d = ticks_per_minute;
					if (sleep_q != '0) begin
						sleep_d = sleep_q - 1'b1;
						alarm   = (sleep_d == '0);
					end
				end
				if (alarm && state_q == PWR_OFF) begin
					sleep_d = '0;
					led_d   = LED_RED;
					state_d = PWR_ON;
				end
			end
			ACT_BUTTON: begin
				if (state_q == PWR_ON) begin
					req = 1'b1;
				end else begin
					sleep_d = '0;
					led_d   = LED_RED;
					state_d = PWR_ON;
				end
			end
			ACT_NONE: begin
			end
			default: begin
			end
		endcase
	end

	assign sleep_32         = 32'(sleep_d);
	assign relay_on         = (state_d == PWR_ON);
	assign led_mode         = led_d;
	assign shutdown_request = req;
	assign sleep_left       = sleep_32[SLEEP_LEFT_W-1:0];

`ifndef SYNTH
	a_on_means_red: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == PWR_ON) == (led_q == LED_RED))
		else $error("power state and led drive disagree");

	a_button_wakes: assert property (@(posedge clk) disable iff (!arst_n)
		step && action == ACT_BUTTON && state_q == PWR_OFF |=> state_q == PWR_ON)
		else $error("button press while off did not switch on");

	a_idle_code_holds: assert property (@(posedge clk) disable iff (!arst_n)
		step && action == ACT_NONE |=> $stable(sleep_q) && $stable(state_q) && $stable(tick_q))
		else $error("unused event code changed state");
`endif

endmodule

// ----- dv/tb_sleep_wake_power_sequencer.sv -----
`timescale 1ns / 100ps

module tb_sleep_wake_power_sequencer;
	import swps_pkg::*;

	// byte patterns, '#' marks places that take a digit and are handled apart
	localparam logic [8*16-1:0] SLEEP_TEXT = "SLEEPTIME #min:#";
	localparam logic [8*21-1:0] HALT_TEXT  = "reboot: System halted";
	localparam int CMD_CHARS  = 16;
	localparam int NUM_AT     = 10;
	localparam int MODE_AT    = 15;
	localparam int HALT_CHARS = 21;

	localparam logic [12:0] TICKS_AT_RESET    = 13'd6000;
	localparam logic [15:0] FALLBACK_AT_RESET = 16'd1440;
	localparam int PHASE_EVENTS = 360;

	typedef struct packed {
		act_t       act;
		logic [7:0] data;
	} stim_t;

	typedef struct packed {
		pwr_state_t  relay;
		led_t        led;
		logic        req;
		logic [15:0] left;
	} status_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata  = '0;   // rx_byte
	logic [1:0]            s_axis_tuser  = '0;   // action
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;         // relay_on, led_mode, shutdown_request,
	                                             // sleep_left, zero fill
	logic                  psel    = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite  = 1'b0;
	logic [ADDR_W-1:0]     paddr   = '0;
	logic [31:0]           pwdata  = '0;
	logic [31:0]           prdata;
	logic                  pready;

	// predictor copy of the block
	logic [12:0] tpm_cfg      = TICKS_AT_RESET;
	logic [15:0] fallback_cfg = FALLBACK_AT_RESET;
	logic [4:0]  cmd_pos      = '0;
	logic [15:0] mins_acc     = '0;
	logic        mode_bit     = 1'b0;
	logic [4:0]  halt_pos     = '0;
	logic [12:0] tick_left    = TICKS_AT_RESET;
	logic [15:0] sleep_mins   = '0;
	logic        sig_mode     = 1'b0;
	pwr_state_t  host_pwr     = PWR_ON;
	led_t        led_now      = LED_RED;

	stim_t   pending_events[$];
	status_t status_due[$];
	stim_t   next_ev;
	status_t due_now;
	int      n_offered  = 0;
	int      n_taken    = 0;
	int      n_err      = 0;
	int      n_results  = 0;
	int      n_off      = 0;
	int      n_wake     = 0;
	int      n_requests = 0;
	int      n_real     = 0;
	bit      no_gaps    = 1'b0;

	sleep_wake_power_sequencer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void wake_host();
		sleep_mins = '0;
		led_now    = LED_RED;
		host_pwr   = PWR_ON;
		n_wake++;
	endfunction

	// host status after one event, advancing the predictor state
	function automatic status_t status_after(input act_t act, input logic [7:0] ch);
		status_t res;
		logic [4:0] p;
		logic miss, alarm, req, is_dig;
		miss   = 1'b0;
		alarm  = 1'b0;
		req    = 1'b0;
		is_dig = (ch >= 8'h30) && (ch <= 8'h39);
		case (act)
			ACT_BYTE: begin
				p = cmd_pos;
				if (p == NUM_AT) begin
					if (is_dig)
						mins_acc = 16'(mins_acc * 10 + ch - 8'h30);
					else if (ch == "m")
						p = 5'(NUM_AT + 2);
					else
						miss = 1'b1;
				end else if (p == MODE_AT) begin
					if (is_dig) begin
						mode_bit = ch[0];
						p = p + 1'b1;
					end else
						miss = 1'b1;
				end else if (ch == SLEEP_TEXT[8*(CMD_CHARS-1-p) +: 8])
					p = p + 1'b1;
				else
					miss = 1'b1;
				if (miss) begin
					p = '0;
					mins_acc = '0;
				end
				if (p == CMD_CHARS) begin
					cmd_pos    = '0;
					sleep_mins = mins_acc;
					sig_mode   = mode_bit;
				end else
					cmd_pos = p;

				// halt matcher, no retry of the failing byte
				if (ch == HALT_TEXT[8*(HALT_CHARS-1-halt_pos) +: 8])
					halt_pos = halt_pos + 1'b1;
				else
					halt_pos = '0;
				if (halt_pos == HALT_CHARS) begin
					halt_pos = '0;
					if (host_pwr == PWR_ON) begin
						if (sleep_mins == 0) begin
							sleep_mins = fallback_cfg;
							sig_mode   = 1'b1;
						end
						led_now  = led_t'({1'b0, sig_mode});
						host_pwr = PWR_OFF;
						n_off++;
					end
				end
			end
			ACT_TICK: begin
				tick_left = tick_left - 1'b1;
				if (tick_left == 0) begin
					tick_left = tpm_cfg;
					if (sleep_mins != 0) begin
						sleep_mins = sleep_mins - 1'b1;
						alarm = (sleep_mins == 0);
					end
				end
				if (alarm && host_pwr == PWR_OFF)
					wake_host();
			end
			ACT_BUTTON: begin
				if (host_pwr == PWR_ON) begin
					req = 1'b1;
					n_requests++;
				end else
					wake_host();
			end
			default: ;
		endcase
		res.relay = host_pwr;
		res.led   = led_now;
		res.req   = req;
		res.left  = sleep_mins;
		return res;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
			n_err++;
		end
	endtask

	// event source: hold until the transfer happens, then maybe idle
	always @(negedge clk) begin
		if (arst_n && !(s_axis_tvalid && n_taken != n_offered)) begin
			if (pending_events.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 33)) begin
				next_ev = pending_events.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tuser  <= next_ev.act;
				s_axis_tdata  <= next_ev.data;
				n_offered     <= n_offered + 1;
			end else
				s_axis_tvalid <= 1'b0;
		end
	end

	always @(negedge clk) begin
		m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= 33);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (status_due.size() == 0) begin
					$display("%0t ns: expected no result, got %h", $time, m_axis_tdata);
					n_err++;
				end else begin
					due_now = status_due.pop_front();
					check_field("relay_on", 16'(due_now.relay), 16'(m_axis_tdata[0]));
					check_field("led_mode", 16'(due_now.led), 16'(m_axis_tdata[2:1]));
					check_field("shutdown_request", 16'(due_now.req), 16'(m_axis_tdata[3]));
					check_field("sleep_left", due_now.left, m_axis_tdata[19:4]);
					check_field("zero fill", 16'd0, 16'(m_axis_tdata[23:20]));
					n_results++;
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				status_due.push_back(status_after(act_t'(s_axis_tuser), s_axis_tdata));
				n_taken <= n_taken + 1;
			end
		end
	end

	task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == REG_TPM_ADDR)
			tpm_cfg = data[12:0];
		else if (addr == REG_FALLBACK_ADDR)
			fallback_cfg = data[15:0];
	endtask

	task automatic reg_check(input logic [ADDR_W-1:0] addr, input logic [31:0] want);
		logic [31:0] got;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		got = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== want) begin
			$display("%0t ns: register at %0d expected %0d, got %0d", $time, addr, want, got);
			n_err++;
		end
	endtask

	task automatic set_regs(input logic [12:0] tpm, input logic [15:0] fallback);
		reg_write(REG_TPM_ADDR, {19'd0, tpm});
		reg_write(REG_FALLBACK_ADDR, {16'd0, fallback});
		reg_check(REG_TPM_ADDR, {19'd0, tpm});
		reg_check(REG_FALLBACK_ADDR, {16'd0, fallback});
	endtask

	task automatic put(input act_t act, input logic [7:0] data);
		stim_t s;
		s.act  = act;
		s.data = data;
		pending_events.push_back(s);
		if (act != ACT_NONE)
			n_real++;
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put(ACT_BYTE, s[i]);
	endtask

	task automatic put_ticks(input int n);
		repeat (n) put(ACT_TICK, 8'($urandom_range(0, 255)));
	endtask

	task automatic put_sleep_cmd(input int ndig, input int top);
		put_text("SLEEPTIME ");
		for (int i = 0; i < ndig; i++)
			put(ACT_BYTE, 8'('h30 + ((i == 0) ? $urandom_range(0, top) : $urandom_range(0, 9))));
		put_text("min:");
		put(ACT_BYTE, 8'('h30 + $urandom_range(0, 9)));
	endtask

	task automatic put_random_seq();
		int    k;
		int    cut;
		string s;
		k = $urandom_range(0, 99);
		if (k < 22) begin
			if ($urandom_range(0, 3) != 0)
				put_sleep_cmd(1, 3);
			else
				put_sleep_cmd($urandom_range(0, 7), 9);
		end else if (k < 34)
			put_text("reboot: System halted");
		else if (k < 58)
			put_ticks($urandom_range(1, 30));
		else if (k < 68)
			put(ACT_BUTTON, 8'($urandom_range(0, 255)));
		else if (k < 78) begin
			repeat ($urandom_range(1, 6)) put(ACT_BYTE, 8'($urandom_range(0, 255)));
		end else if (k < 96) begin
			// pattern cut short, sometimes with a tick or button between the bytes
			s = ($urandom_range(0, 1) != 0) ? "SLEEPTIME 12min:3" : "reboot: System halted";
			cut = $urandom_range(1, s.len() - 1);
			put_text(s.substr(0, cut - 1));
			case ($urandom_range(0, 3))
				0: put(ACT_TICK, 8'($urandom_range(0, 255)));
				1: put(ACT_BUTTON, 8'($urandom_range(0, 255)));
				default: put(ACT_BYTE, 8'($urandom_range(0, 255)));
			endcase
			if ($urandom_range(0, 1) != 0)
				put_text(s.substr(cut, s.len() - 1));
		end else
			put(ACT_NONE, 8'($urandom_range(0, 255)));
	endtask

	task automatic wait_idle();
		while (pending_events.size() != 0 || s_axis_tvalid || status_due.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		reg_check(REG_TPM_ADDR, {19'd0, TICKS_AT_RESET});
		reg_check(REG_FALLBACK_ADDR, {16'd0, FALLBACK_AT_RESET});

		put(ACT_NONE, 8'hff);
		put(ACT_BUTTON, 8'h00);                   // shutdown request while on
		put_text("SLEEPTIME min:4");              // no digits given
		put_text("SLEEPTIME 99999min:3");         // minute count wraps
		put_text("reboot: System halted");        // off, blinking led
		put_text("reboot: System halted");        // halt while off is ignored
		put(ACT_BUTTON, 8'hff);                   // wake
		put_text("reboot: System halted");        // no minutes set: fallback
		put(ACT_BUTTON, 8'h5a);
		put_text("SLEEPTIME 2min:8SLEEPTIME 1min:1");   // digits add onto the kept count
		put_text("SSLEEPTIME 3min:x");            // failing byte is not retried
		put_text("rebooreboot: System halted");
		wait_idle();

		// first countdown runs from the reset period; sleep two minutes while off
		set_regs(13'd2, FALLBACK_AT_RESET);
		put_text("SLEEPTIME 2min:6");
		put_text("reboot: System halted");
		put_ticks(6004);
		put_text("SLEEPTIME 1min:0");             // alarm while on
		put_ticks(4);
		wait_idle();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: set_regs(13'd1, 16'd1);
				1: set_regs(13'd3, 16'd65535);
				2: set_regs(13'd0, 16'd0);
				3: set_regs(13'd8191, 16'd7);
				default: set_regs(13'($urandom_range(1, 6)), 16'($urandom_range(1, 20)));
			endcase
			no_gaps = (ph == 0);
			n_real = 0;
			while (n_real < PHASE_EVENTS)
				put_random_seq();
			wait_idle();
		end
		no_gaps = 1'b0;

		repeat (8) @(posedge clk);
		if (status_due.size() != 0) begin
			$display("%0t ns: %0d results expected, none received", $time, status_due.size());
			n_err++;
		end
		$display("%0d events, %0d results checked over seven register settings incl. zero values",
			n_taken, n_results);
		$display("host switched off %0d times, woken %0d times, %0d shutdown requests",
			n_off, n_wake, n_requests);
		if (n_err == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("%0t ns: timeout, %0d events still queued", $time, pending_events.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/swps_pkg.sv
hw/rtl/swps_match.sv
hw/rtl/swps_power.sv
hw/rtl/sleep_wake_power_sequencer.sv
dv/tb_sleep_wake_power_sequencer.sv
